[src/sha512_pkg.sv]
// SHA-512 package: round constants, initial hash values, padding words, sequencer state codes.
// No dependencies.
`default_nettype none
package sha512_pkg;

    localparam int Rounds      = 80;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [7:0]  PadByte = 8'h80;
    localparam logic [63:0] PadWord = 64'h8000000000000000;

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] v;
        case (idx)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

[src/sha512_stream_hasher_core.sv]
// SHA-512 streaming hasher top level: input framing, padding, sequencer and
// digest output. Uses sha512_pkg and sha512_round.
//
// Input channel (i_valid/o_ready) takes big-endian 64-bit message words;
// i_final_word marks the last one, whose i_valid_bytes gives its 0..8 leading
// bytes. Each word is shifted into a 16-word block buffer. The sixteenth
// word starts compression: 80 rounds at one per cycle through the shared round
// unit, then a fold of the result into the chaining value.
// A final word triggers padding: zero and length words are shifted in one per
// cycle, with a second block when the length does not fit.
// The eight digest words then leave on the output channel (o_valid/i_ready)
// one per transfer, word_index 0 first and digest_last on the eighth.
// o_ready is low while compressing, folding, padding or emitting; a stalled
// receiver simply holds the block in the output state. Reset (synchronous,
// active low) restores the initial hash values and empties the buffer and
// byte count.
`default_nettype none
module sha512_stream_hasher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_message_word,
    input  wire logic [3:0]  i_valid_bytes,
    input  wire logic        i_final_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_last
);
    logic [2:0]   r_state, n_state;
    logic [3:0]   r_fill;
    logic [63:0]  r_total;
    logic [6:0]   r_round;
    logic [2:0]   r_idx;
    logic         r_pad;       // padding pending after current compression
    logic         r_last_len;  // current padding block carries the length
    logic         r_owe80;     // 0x80 word still owed after a full final word
    logic         r_extra;     // tail ended at index 14: zero slot 15, length next block
    logic [511:0] r_hash;
    logic [511:0] v_state;

    logic         acc, load, start, step;
    logic [63:0]  load_word, in_word, keep, padw;
    logic [3:0]   nb;
    logic [63:0]  total_new;

    assign o_ready = (r_state == sha512_pkg::ST_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = (r_state == sha512_pkg::ST_OUT);
    assign o_digest_word = r_hash[511 - 64*r_idx -: 64];
    assign o_word_index  = r_idx;
    assign o_digest_last = (r_idx == 3'd7);

    always_comb begin
        nb = (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;
        keep = (nb == 4'd0) ? 64'h0 : ~64'h0 << (7'd64 - {nb, 3'b000});
        padw = {56'h0, sha512_pkg::PadByte} << (6'd56 - {nb[2:0], 3'b000});
        if (!i_final_word) begin
            in_word = i_message_word;
            total_new = r_total + 64'd8;
        end else begin
            // full final word: pad word follows in the next slot
            in_word = (nb == 4'd8) ? i_message_word : ((i_message_word & keep) | padw);
            total_new = r_total + {60'h0, nb};
        end
    end

    always_comb begin
        load = 1'b0;
        load_word = in_word;
        if (acc) load = 1'b1;
        else if (r_state == sha512_pkg::ST_PAD) begin
            load = 1'b1;
            if (r_owe80) load_word = sha512_pkg::PadWord;
            else if (r_fill == 4'd15 && !r_extra) load_word = {r_total[60:0], 3'b000};
            else load_word = 64'h0;
        end
    end

    assign start = load && (r_fill == 4'd15);
    assign step  = (r_state == sha512_pkg::ST_COMP);

    sha512_round u_round (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_word  (load_word),
        .i_start (start),
        .i_hash  (r_hash),
        .i_step  (step),
        .i_round (r_round),
        .o_state (v_state)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha512_pkg::ST_IDLE: if (acc) begin
                if (r_fill == 4'd15) n_state = sha512_pkg::ST_COMP;
                else if (i_final_word) n_state = sha512_pkg::ST_PAD;
            end
            sha512_pkg::ST_PAD:  if (r_fill == 4'd15) n_state = sha512_pkg::ST_COMP;
            sha512_pkg::ST_COMP: if (r_round == 7'(sha512_pkg::Rounds - 1))
                n_state = sha512_pkg::ST_ADD;
            sha512_pkg::ST_ADD:  n_state = !r_pad ? sha512_pkg::ST_IDLE :
                                 (r_last_len ? sha512_pkg::ST_OUT : sha512_pkg::ST_PAD);
            sha512_pkg::ST_OUT:  if (i_ready && r_idx == 3'd7) n_state = sha512_pkg::ST_IDLE;
            default:             n_state = sha512_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha512_pkg::ST_IDLE;
            r_fill  <= 4'd0;
            r_total <= 64'h0;
            r_round <= 7'd0;
            r_idx   <= 3'd0;
            r_pad   <= 1'b0;
            r_last_len <= 1'b0;
            r_owe80 <= 1'b0;
            r_extra <= 1'b0;
            for (int i = 0; i < 8; i++) r_hash[511-64*i -: 64] <= sha512_pkg::init_hash(3'(i));
        end else begin
            r_state <= n_state;
            if (load) r_fill <= r_fill + 4'd1;
            if (acc) begin
                r_total <= total_new;
                if (i_final_word) begin
                    r_pad   <= 1'b1;
                    r_owe80 <= (nb == 4'd8);
                    r_extra <= (nb != 4'd8) && (r_fill == 4'd14);
                end
            end else if (r_state == sha512_pkg::ST_PAD) begin
                if (r_owe80) begin
                    r_owe80 <= 1'b0;
                    r_extra <= (r_fill == 4'd14);
                end else if (r_fill == 4'd15) begin
                    r_extra <= 1'b0;
                    if (!r_extra) r_last_len <= 1'b1;
                end
            end
            if (step) r_round <= r_round + 7'd1;
            else r_round <= 7'd0;
            if (r_state == sha512_pkg::ST_ADD) begin
                for (int i = 0; i < 8; i++)
                    r_hash[511-64*i -: 64] <= r_hash[511-64*i -: 64] + v_state[511-64*i -: 64];
            end
            if (o_valid && i_ready) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_pad <= 1'b0;
                    r_last_len <= 1'b0;
                    r_total <= 64'h0;
                    for (int i = 0; i < 8; i++)
                        r_hash[511-64*i -: 64] <= sha512_pkg::init_hash(3'(i));
                end
            end
        end
    end

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha512_pkg::ST_COMP) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word_index)))
        else $error("output dropped");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> (r_round < 7'(sha512_pkg::Rounds))) else $error("round overrun");
endmodule
`default_nettype wire

[src/sha512_round.sv]
// SHA-512 round engine: a 16-entry rolling schedule window and the working
// registers a..h, one round per cycle while i_step is high. Uses sha512_pkg.
`default_nettype none
module sha512_round (
    input  wire logic        i_clk,
    input  wire logic        i_load,    // shift a new block word into the window
    input  wire logic [63:0] i_word,
    input  wire logic        i_start,   // copy chaining value into a..h
    input  wire logic [511:0] i_hash,
    input  wire logic        i_step,
    input  wire logic [6:0]  i_round,
    output logic [511:0]     o_state
);
    logic [63:0] r_w [16];
    logic [63:0] r_v [8];
    logic [63:0] w_t, s0, s1, w_new, a, e, t1, t2;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    always_comb begin
        w_t   = r_w[0];
        s0    = ror(r_w[1], 1) ^ ror(r_w[1], 8) ^ (r_w[1] >> 7);
        s1    = ror(r_w[14], 19) ^ ror(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        a     = r_v[0];
        e     = r_v[4];
        t1    = r_v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
                + ((e & r_v[5]) ^ (~e & r_v[6])) + sha512_pkg::round_k(i_round) + w_t;
        t2    = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
                + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_load || i_step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_load ? i_word : w_new;
        end
        if (i_start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_hash[511-64*i -: 64];
        end else if (i_step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_state[511-64*i -: 64] = r_v[i];
    end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for sha512_stream_hasher_core: random and directed messages,
// predicted digests checked word by word. Depends on sha512_pkg and the RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    class digest_board;
        logic [63:0] chain [8];
        logic [63:0] blk [16];
        int unsigned fill;
        logic [63:0] nbytes;
        logic [63:0] pending_word [$];
        logic [2:0]  pending_idx [$];
        logic        pending_last [$];
        int unsigned errors;
        int unsigned words_seen;
        int unsigned digests_seen;

        function new();
            restart();
            errors = 0;
            words_seen = 0;
            digests_seen = 0;
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = iv_word(i);
            fill = 0;
            nbytes = 0;
        endfunction

        function logic [63:0] iv_word(int i);
            logic [63:0] iv [8];
            iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                   64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                   64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
            return iv[i];
        endfunction

        function logic [63:0] rotr(logic [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress();
            logic [63:0] w [80];
            logic [63:0] v [8];
            logic [63:0] s0, s1, t1, t2;
            for (int t = 0; t < 16; t++) w[t] = blk[t];
            for (int t = 16; t < 80; t++) begin
                s0 = rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7);
                s1 = rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int t = 0; t < 80; t++) begin
                t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::round_k(t[6:0]) + w[t];
                t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void push(logic [63:0] w);
            blk[fill] = w;
            fill++;
            if (fill == 16) begin
                compress();
                fill = 0;
            end
        endfunction

        // Note one accepted message word and queue the digest it completes.
        function void note_word(logic [63:0] word, logic [3:0] vb, logic fin);
            int unsigned n;
            logic [63:0] keep;
            words_seen++;
            if (!fin) begin
                push(word);
                nbytes += 8;
                return;
            end
            n = (vb > 8) ? 8 : vb;
            nbytes += n;
            if (n == 8) begin
                push(word);
                push(sha512_pkg::PadWord);
            end else begin
                keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
                push((word & keep) | (64'(sha512_pkg::PadByte) << (56 - 8 * n)));
            end
            if (fill > 14) while (fill != 0) push(64'd0);
            while (fill < 14) push(64'd0);
            push(64'd0);
            push(nbytes << 3);
            for (int k = 0; k < 8; k++) begin
                pending_word.push_back(chain[k]);
                pending_idx.push_back(k[2:0]);
                pending_last.push_back(k == 7);
            end
            restart();
        endfunction

        function void check_digest(logic [63:0] dw, logic [2:0] idx, logic last);
            logic [63:0] ew;
            logic [2:0] ei;
            logic el;
            if (pending_word.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected digest word %h idx %0d", dw, idx);
                return;
            end
            ew = pending_word.pop_front();
            ei = pending_idx.pop_front();
            el = pending_last.pop_front();
            if (last) digests_seen++;
            if (dw !== ew || idx !== ei || last !== el) begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                             ew, ei, el, dw, idx, last);
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_ready = 0;
    logic [63:0] i_message_word = 0;
    logic [3:0]  i_valid_bytes = 0;
    logic        i_final_word = 0;
    logic        o_ready, o_valid, o_digest_last;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;

    int unsigned send_idle_pct = 10, recv_idle_pct = 64;
    int unsigned holdoff = 0;
    digest_board board = new();

    sha512_stream_hasher_core DUT (.*);

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) if (i_rst_n) begin
        if (i_valid && o_ready) board.note_word(i_message_word, i_valid_bytes, i_final_word);
        if (o_valid && i_ready) board.check_digest(o_digest_word, o_word_index, o_digest_last);
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Leave valid high after the transfer; the next call drops or reloads it.
    task automatic send_word(logic [63:0] w, logic [3:0] vb, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_message_word <= w;
        i_valid_bytes <= vb;
        i_final_word <= fin;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random message: mostly short, a few spanning several blocks.
    task automatic send_message();
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
        repeat (len) send_word(rand64(), 4'($urandom_range(15)), 1'b0);
        send_word(rand64(), 4'($urandom_range(15)), 1'b1);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: empty message, every tail byte count, oversized count,
        // all-ones/all-zero words, and the tail sizes that force an extra block.
        send_word(64'd0, 4'd0, 1'b1);
        for (int n = 0; n <= 9; n++) send_word(~64'd0, 4'(n), 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
        repeat (14) send_word(64'd0, 4'd3, 1'b0);
        send_word(~64'd0, 4'd8, 1'b1);
        repeat (15) send_word(~64'd0, 4'd0, 1'b0);
        send_word(64'h0123456789abcdef, 4'd1, 1'b1);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 10 : 0;
            if (phase == 2) holdoff = 400;
            while (board.words_seen < 40 + 80 * (phase + 1)) send_message();
        end
        i_valid <= 1'b0;
        while (board.pending_word.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Covered %0d message words and %0d digests, all tail sizes and stalls.",
                 board.words_seen, board.digests_seen);
        if (board.errors == 0 && board.pending_word.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
